// ===== rtl/awbg_pkg.sv =====
package awbg_pkg;

    localparam int PIX_W    = 16;
    localparam int VAL_W    = 24;
    localparam int GRAD_W   = 25;
    localparam int FRAC_W   = 14;
    localparam int LINE_W   = 7;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int QUEUE_DEPTH = 16;
    localparam int QUEUE_AW    = 4;

    typedef logic [LINE_W-1:0]   line_t;
    typedef logic [QUEUE_AW-1:0] qptr_t;
    typedef logic [QUEUE_AW:0]   qcnt_t;

    localparam qcnt_t QCNT_FULL = qcnt_t'(QUEUE_DEPTH);

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_RESAMPLE = 1'b1;

    localparam logic [IDX_W-1:0] REG_LINE_SHIFT         = 3'd0;
    localparam logic [IDX_W-1:0] REG_LINE_FROM_LINE     = 3'd1;
    localparam logic [IDX_W-1:0] REG_LINE_FROM_SAMPLE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SAMPLE_SHIFT       = 3'd3;
    localparam logic [IDX_W-1:0] REG_SAMPLE_FROM_LINE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SAMPLE_FROM_SAMPLE = 3'd5;

    typedef struct packed {
        logic signed [CFG_W-1:0] line_shift;
        logic signed [CFG_W-1:0] line_from_line;
        logic signed [CFG_W-1:0] line_from_sample;
        logic signed [CFG_W-1:0] sample_shift;
        logic signed [CFG_W-1:0] sample_from_line;
        logic signed [CFG_W-1:0] sample_from_sample;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        line_shift:         16'sd0,
        line_from_line:     16'sd16384,
        line_from_sample:   16'sd0,
        sample_shift:       16'sd0,
        sample_from_line:   16'sd0,
        sample_from_sample: 16'sd16384
    };

    typedef struct packed {
        logic              valid;
        logic              load;
        logic              oor;
        line_t             line;
        line_t             samp;
        logic [PIX_W-1:0]  pixel;
        logic [FRAC_W-1:0] fl;
        logic [FRAC_W-1:0] fs;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic              oor;
        logic [FRAC_W-1:0] fl;
        logic [FRAC_W-1:0] fs;
        logic [PIX_W-1:0]  p00;
        logic [PIX_W-1:0]  p01;
        logic [PIX_W-1:0]  p10;
        logic [PIX_W-1:0]  p11;
    } nbhd_t;

    typedef struct packed {
        logic [VAL_W-1:0]         value;
        logic signed [GRAD_W-1:0] grad_line;
        logic signed [GRAD_W-1:0] grad_sample;
        logic                     oor;
    } res_t;

endpackage

// ===== rtl/awbg_ram.sv =====
module awbg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 169,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/awbg_map.sv =====
module awbg_map #(
    parameter int WIN_LINES   = 15,
    parameter int WIN_SAMPLES = 15,
    parameter int BORDER      = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic                 in_command,
    input  logic [4:0]           in_row,
    input  logic [4:0]           in_col,
    input  logic [15:0]          in_pixel,
    input  awbg_pkg::cfg_t       cfg,
    output awbg_pkg::req_t       req
);

    localparam int TGT_LINES   = WIN_LINES + 2 * BORDER;
    localparam int TGT_SAMPLES = WIN_SAMPLES + 2 * BORDER;
    localparam int CTR_LINE    = (WIN_LINES - 1) / 2;
    localparam int CTR_SAMPLE  = (WIN_SAMPLES - 1) / 2;
    localparam int ORG_LINE    = CTR_LINE + BORDER;
    localparam int ORG_SAMPLE  = CTR_SAMPLE + BORDER;

    logic signed [6:0]  dl, ds;
    logic signed [22:0] dl_x, ds_x;
    logic signed [22:0] a1_x, a2_x, b1_x, b2_x;
    logic signed [22:0] pa1_next, pa2_next, pb1_next, pb2_next;

    logic               v1_reg, cmd1_reg;
    logic [4:0]         row1_reg, col1_reg;
    logic [15:0]        pix1_reg;
    logic signed [22:0] pa1_reg, pa2_reg, pb1_reg, pb2_reg;

    logic signed [25:0] l14_next, s14_next;
    logic               v2_reg, cmd2_reg;
    logic [4:0]         row2_reg, col2_reg;
    logic [15:0]        pix2_reg;
    logic signed [25:0] l14_reg, s14_reg;

    logic signed [11:0] li, si;
    logic               line_oor, samp_oor, load_oor, is_load;

    assign dl   = 7'(in_row) - 7'(CTR_LINE);
    assign ds   = 7'(in_col) - 7'(CTR_SAMPLE);
    assign dl_x = 23'(dl);
    assign ds_x = 23'(ds);
    assign a1_x = 23'(cfg.line_from_line);
    assign a2_x = 23'(cfg.line_from_sample);
    assign b1_x = 23'(cfg.sample_from_line);
    assign b2_x = 23'(cfg.sample_from_sample);

    assign pa1_next = a1_x * dl_x;
    assign pa2_next = a2_x * ds_x;
    assign pb1_next = b1_x * dl_x;
    assign pb2_next = b2_x * ds_x;

    assign l14_next = (26'(cfg.line_shift) <<< 6) + 26'(pa1_reg) + 26'(pa2_reg)
                    + 26'(ORG_LINE * 16384);
    assign s14_next = (26'(cfg.sample_shift) <<< 6) + 26'(pb1_reg) + 26'(pb2_reg)
                    + 26'(ORG_SAMPLE * 16384);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cmd1_reg <= in_command;
        row1_reg <= in_row;
        col1_reg <= in_col;
        pix1_reg <= in_pixel;
        pa1_reg  <= pa1_next;
        pa2_reg  <= pa2_next;
        pb1_reg  <= pb1_next;
        pb2_reg  <= pb2_next;
        cmd2_reg <= cmd1_reg;
        row2_reg <= row1_reg;
        col2_reg <= col1_reg;
        pix2_reg <= pix1_reg;
        l14_reg  <= l14_next;
        s14_reg  <= s14_next;
    end

    assign li = l14_reg[25:14];
    assign si = s14_reg[25:14];

    assign line_oor = li[11] | (li[10:0] >= 11'(TGT_LINES - 1));
    assign samp_oor = si[11] | (si[10:0] >= 11'(TGT_SAMPLES - 1));
    assign load_oor = (awbg_pkg::line_t'(row2_reg) >= awbg_pkg::line_t'(TGT_LINES))
                    | (awbg_pkg::line_t'(col2_reg) >= awbg_pkg::line_t'(TGT_SAMPLES));
    assign is_load  = (cmd2_reg == awbg_pkg::CMD_LOAD);

    always_comb begin
        req.valid = v2_reg;
        req.load  = is_load;
        req.oor   = is_load ? load_oor : (line_oor | samp_oor);
        req.line  = is_load ? awbg_pkg::line_t'(row2_reg) : li[awbg_pkg::LINE_W-1:0];
        req.samp  = is_load ? awbg_pkg::line_t'(col2_reg) : si[awbg_pkg::LINE_W-1:0];
        req.pixel = pix2_reg;
        req.fl    = l14_reg[13:0];
        req.fs    = s14_reg[13:0];
    end

endmodule

// ===== rtl/awbg_window.sv =====
module awbg_window #(
    parameter int TGT_LINES   = 25,
    parameter int TGT_SAMPLES = 25
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  awbg_pkg::req_t  req,
    output awbg_pkg::nbhd_t nbhd
);

    localparam int BANK_ROWS  = (TGT_LINES + 1) / 2;
    localparam int BANK_COLS  = (TGT_SAMPLES + 1) / 2;
    localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LW         = awbg_pkg::LINE_W;

    logic [awbg_pkg::PIX_W-1:0]  bank_q [4];

    logic                        rd_valid_reg;
    logic                        oor_reg, l0_reg, s0_reg;
    logic [awbg_pkg::FRAC_W-1:0] fl_reg, fs_reg;

    // Four parity banks: any 2x2 neighborhood touches each bank exactly once.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PL = 1'(b / 2);
        localparam logic PS = 1'(b % 2);

        logic [LW:0]         lb, sb;
        logic [BANK_AW-1:0]  addr;
        logic                we;

        assign lb   = {1'b0, req.line} + {{LW{1'b0}}, req.line[0] ^ PL};
        assign sb   = {1'b0, req.samp} + {{LW{1'b0}}, req.samp[0] ^ PS};
        assign addr = BANK_AW'(int'(lb[LW:1]) * BANK_COLS + int'(sb[LW:1]));
        assign we   = req.valid & req.load & ~req.oor
                    & (req.line[0] == PL) & (req.samp[0] == PS);

        awbg_ram #(
            .WIDTH (awbg_pkg::PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (aclk),
            .we    (we),
            .waddr (addr),
            .wdata (req.pixel),
            .raddr (addr),
            .rdata (bank_q[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= req.valid & ~req.load;
        end
    end

    always_ff @(posedge aclk) begin
        oor_reg <= req.oor;
        l0_reg  <= req.line[0];
        s0_reg  <= req.samp[0];
        fl_reg  <= req.fl;
        fs_reg  <= req.fs;
    end

    always_comb begin
        nbhd.valid = rd_valid_reg;
        nbhd.oor   = oor_reg;
        nbhd.fl    = fl_reg;
        nbhd.fs    = fs_reg;
        nbhd.p00   = bank_q[{l0_reg, s0_reg}];
        nbhd.p01   = bank_q[{l0_reg, ~s0_reg}];
        nbhd.p10   = bank_q[{~l0_reg, s0_reg}];
        nbhd.p11   = bank_q[{~l0_reg, ~s0_reg}];
    end

endmodule

// ===== rtl/awbg_interp.sv =====
module awbg_interp (
    input  logic            aclk,
    input  logic            aresetn,
    input  awbg_pkg::nbhd_t nbhd,
    output logic            res_valid,
    output awbg_pkg::res_t  res
);

    logic signed [17:0] d1_next;
    logic signed [16:0] d2_next, d3_next;

    logic               v4_reg, oor4_reg;
    logic signed [17:0] d1_reg;
    logic signed [16:0] d2_reg, d3_reg;
    logic [15:0]        p00_4_reg;
    logic [13:0]        fl4_reg, fs4_reg;

    logic signed [31:0] d1_x, d2_x, d3_x, fl_x, fs_x;
    logic signed [31:0] d1fs_next, d1fl_next, d2fs_next, d3fl_next;

    logic               v5_reg, oor5_reg;
    logic signed [31:0] d1fs_reg, d1fl_reg, d2fs_reg, d3fl_reg;
    logic signed [16:0] d2_5_reg, d3_5_reg;
    logic [15:0]        p00_5_reg;
    logic [13:0]        fl5_reg;

    logic signed [47:0] d1fs_w, fl_w, p00_w, d2fs_w, d3fl_w;
    logic signed [47:0] prod_next, part_next;
    logic signed [32:0] gl_sum, gs_sum;

    logic               v6_reg, oor6_reg;
    logic signed [47:0] prod_reg, part_reg;
    logic signed [24:0] gl_reg, gs_reg;

    logic signed [47:0] v28;

    assign d1_next = 18'(nbhd.p11) + 18'(nbhd.p00) - 18'(nbhd.p01) - 18'(nbhd.p10);
    assign d2_next = 17'(nbhd.p01) - 17'(nbhd.p00);
    assign d3_next = 17'(nbhd.p10) - 17'(nbhd.p00);

    assign d1_x = 32'(d1_reg);
    assign d2_x = 32'(d2_reg);
    assign d3_x = 32'(d3_reg);
    assign fl_x = 32'(fl4_reg);
    assign fs_x = 32'(fs4_reg);

    assign d1fs_next = d1_x * fs_x;
    assign d1fl_next = d1_x * fl_x;
    assign d2fs_next = d2_x * fs_x;
    assign d3fl_next = d3_x * fl_x;

    assign d1fs_w    = 48'(d1fs_reg);
    assign fl_w      = 48'(fl5_reg);
    assign p00_w     = 48'(p00_5_reg);
    assign d2fs_w    = 48'(d2fs_reg);
    assign d3fl_w    = 48'(d3fl_reg);
    assign prod_next = d1fs_w * fl_w;
    assign part_next = (p00_w <<< 28) + ((d2fs_w + d3fl_w) <<< 14);

    assign gl_sum = (33'(d3_5_reg) <<< 14) + 33'(d1fs_reg) + 33'sd32;
    assign gs_sum = (33'(d2_5_reg) <<< 14) + 33'(d1fl_reg) + 33'sd32;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            v4_reg <= nbhd.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        oor4_reg  <= nbhd.oor;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        d3_reg    <= d3_next;
        p00_4_reg <= nbhd.p00;
        fl4_reg   <= nbhd.fl;
        fs4_reg   <= nbhd.fs;

        oor5_reg  <= oor4_reg;
        d1fs_reg  <= d1fs_next;
        d1fl_reg  <= d1fl_next;
        d2fs_reg  <= d2fs_next;
        d3fl_reg  <= d3fl_next;
        d2_5_reg  <= d2_reg;
        d3_5_reg  <= d3_reg;
        p00_5_reg <= p00_4_reg;
        fl5_reg   <= fl4_reg;

        oor6_reg  <= oor5_reg;
        prod_reg  <= prod_next;
        part_reg  <= part_next;
        gl_reg    <= gl_sum[30:6];
        gs_reg    <= gs_sum[30:6];
    end

    assign v28 = part_reg + prod_reg + 48'sd524288;

    assign res_valid       = v6_reg;
    assign res.value       = oor6_reg ? '0 : v28[43:20];
    assign res.grad_line   = oor6_reg ? '0 : gl_reg;
    assign res.grad_sample = oor6_reg ? '0 : gs_reg;
    assign res.oor         = oor6_reg;

endmodule

// ===== rtl/affine_bilinear_warp_with_gradient_core.sv =====
// Throughput: one beat per cycle while s_ready is high; the window sits in four
// parity banks, so the 2x2 neighborhood is one read of each single-port bank in
// the same cycle. Load beats give no result and are written at the same stage
// where reads issue. Reset (aresetn, synchronous, active low) empties the
// pipeline and result queue and restores register defaults; window contents
// stay undefined until loaded.
module affine_bilinear_warp_with_gradient_core #(
    parameter int WIN_LINES   = 15,
    parameter int WIN_SAMPLES = 15,
    parameter int BORDER      = 5
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [4:0]         s_row,
    input  logic [4:0]         s_col,
    input  logic [15:0]        s_pixel,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_value,
    output logic signed [24:0] m_grad_line,
    output logic signed [24:0] m_grad_sample,
    output logic               m_out_of_range,

    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int TGT_LINES   = WIN_LINES + 2 * BORDER;
    localparam int TGT_SAMPLES = WIN_SAMPLES + 2 * BORDER;

    awbg_pkg::cfg_t  cfg_reg;
    awbg_pkg::req_t  req;
    awbg_pkg::nbhd_t nbhd;
    awbg_pkg::res_t  res;
    logic            res_valid;

    awbg_pkg::res_t  q_mem_reg [awbg_pkg::QUEUE_DEPTH];
    awbg_pkg::qptr_t wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    awbg_pkg::qcnt_t q_cnt_reg, q_cnt_next, credit_reg, credit_next;

    logic in_accept, take_res, pop;

    assign in_accept = s_valid & s_ready;
    assign take_res  = in_accept & (s_command == awbg_pkg::CMD_RESAMPLE);
    assign pop       = m_valid & m_ready;
    assign s_ready   = (credit_reg != awbg_pkg::QCNT_FULL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= awbg_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                awbg_pkg::REG_LINE_SHIFT:         cfg_reg.line_shift         <= cfg_data;
                awbg_pkg::REG_LINE_FROM_LINE:     cfg_reg.line_from_line     <= cfg_data;
                awbg_pkg::REG_LINE_FROM_SAMPLE:   cfg_reg.line_from_sample   <= cfg_data;
                awbg_pkg::REG_SAMPLE_SHIFT:       cfg_reg.sample_shift       <= cfg_data;
                awbg_pkg::REG_SAMPLE_FROM_LINE:   cfg_reg.sample_from_line   <= cfg_data;
                awbg_pkg::REG_SAMPLE_FROM_SAMPLE: cfg_reg.sample_from_sample <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    awbg_map #(
        .WIN_LINES   (WIN_LINES),
        .WIN_SAMPLES (WIN_SAMPLES),
        .BORDER      (BORDER)
    ) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_command (s_command),
        .in_row     (s_row),
        .in_col     (s_col),
        .in_pixel   (s_pixel),
        .cfg        (cfg_reg),
        .req        (req)
    );

    awbg_window #(
        .TGT_LINES   (TGT_LINES),
        .TGT_SAMPLES (TGT_SAMPLES)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .nbhd    (nbhd)
    );

    awbg_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .nbhd      (nbhd),
        .res_valid (res_valid),
        .res       (res)
    );

    // Credits cover every resample beat in flight, so the queue never overflows.
    assign credit_next = credit_reg + awbg_pkg::qcnt_t'(take_res)
                       - awbg_pkg::qcnt_t'(pop);
    assign q_cnt_next  = q_cnt_reg + awbg_pkg::qcnt_t'(res_valid)
                       - awbg_pkg::qcnt_t'(pop);
    assign wr_ptr_next = wr_ptr_reg + awbg_pkg::qptr_t'(res_valid);
    assign rd_ptr_next = rd_ptr_reg + awbg_pkg::qptr_t'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
            q_cnt_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            credit_reg <= credit_next;
            q_cnt_reg  <= q_cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            q_mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign m_valid        = (q_cnt_reg != '0);
    assign m_value        = q_mem_reg[rd_ptr_reg].value;
    assign m_grad_line    = q_mem_reg[rd_ptr_reg].grad_line;
    assign m_grad_sample  = q_mem_reg[rd_ptr_reg].grad_sample;
    assign m_out_of_range = q_mem_reg[rd_ptr_reg].oor;

endmodule

// ===== rtl/awbg_checker.sv =====
module awbg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_command,
    input logic [4:0]         s_row,
    input logic [4:0]         s_col,
    input logic [15:0]        s_pixel,
    input logic               m_valid,
    input logic               m_ready,
    input logic [23:0]        m_value,
    input logic signed [24:0] m_grad_line,
    input logic signed [24:0] m_grad_sample,
    input logic               m_out_of_range,
    input logic               cfg_wr_en,
    input logic [2:0]         cfg_index,
    input logic [15:0]        cfg_data
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value)
            && $stable(m_grad_line) && $stable(m_grad_sample)
            && $stable(m_out_of_range))
        else $error("stalled result beat changed");

    // An out-of-range beat carries zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |->
            m_value == '0 && m_grad_line == '0 && m_grad_sample == '0)
        else $error("out-of-range beat with nonzero data");

    // The interpolated value never exceeds the largest pixel in Q8.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |-> m_value <= 24'hFFFF00)
        else $error("interpolated value above pixel range");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat pending after reset");

endmodule

bind affine_bilinear_warp_with_gradient_core awbg_checker u_checker (.*);

// ===== dv/tb_affine_bilinear_warp_with_gradient_core.sv =====
module tb_affine_bilinear_warp_with_gradient_core;

    localparam int WIN_LINES      = 15;
    localparam int WIN_SAMPLES    = 15;
    localparam int BORDER         = 5;
    localparam int TGT_LINES      = WIN_LINES + 2 * BORDER;
    localparam int TGT_SAMPLES    = WIN_SAMPLES + 2 * BORDER;
    localparam int CTR_LINE       = (WIN_LINES - 1) / 2;
    localparam int CTR_SAMPLE     = (WIN_SAMPLES - 1) / 2;

    localparam int N_PHASES       = 11;
    localparam int BEATS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT        = 8 * 500000;
    localparam int PLAN_LEN       = 24;

    localparam logic [awbg_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [awbg_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [awbg_pkg::VAL_W-1:0]         value;
        logic signed [awbg_pkg::GRAD_W-1:0] grad_line;
        logic signed [awbg_pkg::GRAD_W-1:0] grad_sample;
        logic                               oor;
    } warp_result_t;

    typedef struct packed {
        logic         cmd;
        logic [4:0]   row;
        logic [4:0]   col;
        logic [15:0]  pix;
        logic         typed;
        warp_result_t result;
    } plan_row_t;

    localparam warp_result_t NO_RESULT  = '{24'd0, 25'sd0, 25'sd0, 1'b0};
    localparam warp_result_t OOR_RESULT = '{24'd0, 25'sd0, 25'sd0, 1'b1};
    localparam warp_result_t FALL_RESULT =
        '{24'hFFFF00, -25'sd16776960, -25'sd16776960, 1'b0};
    localparam warp_result_t RISE_RESULT =
        '{24'd0, 25'sd0, 25'sd16776960, 1'b0};

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic         s_command = awbg_pkg::CMD_LOAD;
    logic [4:0]   s_row = '0;
    logic [4:0]   s_col = '0;
    logic [15:0]  s_pixel = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [23:0]  m_value;
    logic signed [24:0] m_grad_line;
    logic signed [24:0] m_grad_sample;
    logic         m_out_of_range;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    bit              no_idle = 1'b0;
    int              mismatch_count = 0;
    awbg_pkg::cfg_t  warp_cfg = awbg_pkg::CFG_RESET;
    logic [15:0]     window_copy [TGT_LINES * TGT_SAMPLES];
    warp_result_t    expected_warps [$];

    plan_row_t plan [PLAN_LEN] = '{
        '{awbg_pkg::CMD_LOAD,     5'd12, 5'd12, 16'hFFFF, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd12, 5'd13, 16'h0000, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd13, 5'd12, 16'h0000, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd13, 5'd13, 16'hFFFF, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd7,  5'd7,  16'h0000, 1'b1, FALL_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd31, 5'd31, 16'hFFFF, 1'b1, OOR_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd19, 5'd19, 16'h0000, 1'b1, OOR_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd18, 5'd18, 16'h0000, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd0,  5'd0,  16'h0000, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd0,  5'd31, 16'h0000, 1'b1, OOR_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd19, 5'd0,  16'h0000, 1'b1, OOR_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd31, 5'd0,  16'h1234, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd0,  5'd31, 16'h4321, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd25, 5'd25, 16'hAAAA, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd24, 5'd24, 16'hFFFF, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd0,  5'd0,  16'h0000, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd18, 5'd18, 16'h5A5A, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd12, 5'd12, 16'h0000, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd12, 5'd13, 16'hFFFF, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd7,  5'd7,  16'h0000, 1'b1, RISE_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd7,  5'd7,  16'hFFFF, 1'b1, RISE_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd3,  5'd11, 16'h0000, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_LOAD,     5'd5,  5'd5,  16'h5555, 1'b0, NO_RESULT},
        '{awbg_pkg::CMD_RESAMPLE, 5'd0,  5'd0,  16'h0000, 1'b0, NO_RESULT}
    };

    affine_bilinear_warp_with_gradient_core #(
        .WIN_LINES   (WIN_LINES),
        .WIN_SAMPLES (WIN_SAMPLES),
        .BORDER      (BORDER)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_pixel        (s_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_grad_line    (m_grad_line),
        .m_grad_sample  (m_grad_sample),
        .m_out_of_range (m_out_of_range),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic warp_result_t predict_warp(input logic [4:0] row,
                                                  input logic [4:0] col);
        longint dl, ds, l14, s14, li, si, fl, fs;
        longint p00, p01, p10, p11, d1, d2, d3, v28;
        warp_result_t r;
        r = NO_RESULT;
        dl = longint'(row) - CTR_LINE;
        ds = longint'(col) - CTR_SAMPLE;
        l14 = longint'(warp_cfg.line_shift) * 64
            + longint'(warp_cfg.line_from_line) * dl
            + longint'(warp_cfg.line_from_sample) * ds
            + longint'(CTR_LINE + BORDER) * 16384;
        s14 = longint'(warp_cfg.sample_shift) * 64
            + longint'(warp_cfg.sample_from_line) * dl
            + longint'(warp_cfg.sample_from_sample) * ds
            + longint'(CTR_SAMPLE + BORDER) * 16384;
        li = l14 >>> 14;
        si = s14 >>> 14;
        if (li < 0 || li + 1 >= TGT_LINES || si < 0 || si + 1 >= TGT_SAMPLES) begin
            r.oor = 1'b1;
            return r;
        end
        fl = l14 - li * 16384;
        fs = s14 - si * 16384;
        p00 = window_copy[int'(li * TGT_SAMPLES + si)];
        p01 = window_copy[int'(li * TGT_SAMPLES + si + 1)];
        p10 = window_copy[int'((li + 1) * TGT_SAMPLES + si)];
        p11 = window_copy[int'((li + 1) * TGT_SAMPLES + si + 1)];
        d1 = p11 + p00 - p01 - p10;
        d2 = p01 - p00;
        d3 = p10 - p00;
        v28 = p00 * 268435456 + d2 * fs * 16384 + d3 * fl * 16384 + d1 * fs * fl;
        r.value       = 24'((v28 + 524288) >>> 20);
        r.grad_line   = 25'((d3 * 16384 + d1 * fs + 32) >>> 6);
        r.grad_sample = 25'((d2 * 16384 + d1 * fl + 32) >>> 6);
        return r;
    endfunction

    function automatic awbg_pkg::cfg_t cfg_for_phase(input int phase);
        awbg_pkg::cfg_t c;
        c = awbg_pkg::CFG_RESET;
        case (phase)
            1: c = '0;
            2: c = {6{16'sh7FFF}};
            3: c = {6{16'sh8000}};
            4: begin
                c.line_shift   = 16'sd128;
                c.sample_shift = -16'sd96;
            end
            5: c = awbg_pkg::cfg_t'({$urandom, $urandom, $urandom});
            default: begin
                c.line_shift         = 16'(int'($urandom_range(0, 3072)) - 1536);
                c.sample_shift       = 16'(int'($urandom_range(0, 3072)) - 1536);
                c.line_from_line     = 16'(int'($urandom_range(0, 12000)) + 10384);
                c.sample_from_sample = 16'(int'($urandom_range(0, 12000)) + 10384);
                c.line_from_sample   = 16'(int'($urandom_range(0, 8000)) - 4000);
                c.sample_from_line   = 16'(int'($urandom_range(0, 8000)) - 4000);
            end
        endcase
        return c;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic write_reg(input logic [awbg_pkg::IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            awbg_pkg::REG_LINE_SHIFT:         warp_cfg.line_shift = data;
            awbg_pkg::REG_LINE_FROM_LINE:     warp_cfg.line_from_line = data;
            awbg_pkg::REG_LINE_FROM_SAMPLE:   warp_cfg.line_from_sample = data;
            awbg_pkg::REG_SAMPLE_SHIFT:       warp_cfg.sample_shift = data;
            awbg_pkg::REG_SAMPLE_FROM_LINE:   warp_cfg.sample_from_line = data;
            awbg_pkg::REG_SAMPLE_FROM_SAMPLE: warp_cfg.sample_from_sample = data;
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input awbg_pkg::cfg_t c);
        write_reg(awbg_pkg::REG_LINE_SHIFT, c.line_shift);
        write_reg(awbg_pkg::REG_LINE_FROM_LINE, c.line_from_line);
        write_reg(awbg_pkg::REG_LINE_FROM_SAMPLE, c.line_from_sample);
        write_reg(awbg_pkg::REG_SAMPLE_SHIFT, c.sample_shift);
        write_reg(awbg_pkg::REG_SAMPLE_FROM_LINE, c.sample_from_line);
        write_reg(awbg_pkg::REG_SAMPLE_FROM_SAMPLE, c.sample_from_sample);
    endtask

    task automatic send_beat(input logic cmd, input logic [4:0] row,
                             input logic [4:0] col, input logic [15:0] pix,
                             input logic typed, input warp_result_t typed_res);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_row     <= row;
        s_col     <= col;
        s_pixel   <= pix;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (cmd == awbg_pkg::CMD_LOAD) begin
            if (row < TGT_LINES && col < TGT_SAMPLES) begin
                window_copy[int'(row) * TGT_SAMPLES + int'(col)] = pix;
            end
        end else begin
            expected_warps.push_back(typed ? typed_res : predict_warp(row, col));
        end
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_warps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [4:0] pick_coord(input int in_max);
        return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, in_max));
    endfunction

    initial begin : stimulus
        logic [4:0] row;
        logic [4:0] col;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every window entry gets written before any resample can read it.
        for (int l = 0; l < TGT_LINES; l++) begin
            for (int s = 0; s < TGT_SAMPLES; s++) begin
                send_beat(awbg_pkg::CMD_LOAD, 5'(l), 5'(s), 16'($urandom), 1'b0,
                          NO_RESULT);
            end
        end

        foreach (plan[i]) begin
            send_beat(plan[i].cmd, plan[i].row, plan[i].col, plan[i].pix,
                      plan[i].typed, plan[i].result);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            if (phase != 0) begin
                apply_cfg(cfg_for_phase(phase));
                if (phase == 5) begin
                    write_reg(REG_SPARE_LO, 16'($urandom));
                    write_reg(REG_SPARE_HI, 16'($urandom));
                end
                cfg_wr_en <= 1'b0;
            end
            if (phase == N_PHASES - 1) begin
                no_idle <= 1'b1;
            end
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    row = pick_coord(TGT_LINES - 1);
                    col = pick_coord(TGT_SAMPLES - 1);
                    send_beat(awbg_pkg::CMD_LOAD, row, col, 16'($urandom), 1'b0,
                              NO_RESULT);
                end else begin
                    row = pick_coord(18);
                    col = pick_coord(18);
                    send_beat(awbg_pkg::CMD_RESAMPLE, row, col, 16'($urandom), 1'b0,
                              NO_RESULT);
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("affine_bilinear_warp_with_gradient_core regression: pass");
        end else begin
            $display("affine_bilinear_warp_with_gradient_core regression: fail");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        int received;
        bit held;
        warp_result_t want;
        gap = 0;
        received = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                received++;
                if (expected_warps.size() == 0) begin
                    note_mismatch("result beat arrived with nothing pending");
                end else begin
                    want = expected_warps.pop_front();
                    if (m_value !== want.value)
                        note_mismatch($sformatf("value: expected %0d, got %0d",
                                                want.value, m_value));
                    if (m_grad_line !== want.grad_line)
                        note_mismatch($sformatf("grad_line: expected %0d, got %0d",
                                                want.grad_line, m_grad_line));
                    if (m_grad_sample !== want.grad_sample)
                        note_mismatch($sformatf("grad_sample: expected %0d, got %0d",
                                                want.grad_sample, m_grad_sample));
                    if (m_out_of_range !== want.oor)
                        note_mismatch($sformatf("out_of_range: expected %0d, got %0d",
                                                want.oor, m_out_of_range));
                end
            end
            // A single long hold-off lets the block fill up and push back on its input.
            if (!held && received >= HOLDOFF_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                if (gap == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
                    gap = $urandom_range(1, 7);
                end
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    gap--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("affine_bilinear_warp_with_gradient_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/awbg_pkg.sv
rtl/awbg_ram.sv
rtl/awbg_map.sv
rtl/awbg_window.sv
rtl/awbg_interp.sv
rtl/affine_bilinear_warp_with_gradient_core.sv
rtl/awbg_checker.sv
dv/tb_affine_bilinear_warp_with_gradient_core.sv
